// ===== sv/aes_cbc_field_cipher_top_macros.svh =====
// Assertion macros for the AES-CBC field cipher.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef AES_CBC_FIELD_CIPHER_TOP_MACROS_SVH
`define AES_CBC_FIELD_CIPHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ACFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acfc: same-cycle check failed");
`define ACFC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acfc: next-cycle check failed");
`else
`define ACFC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ACFC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/acfc_pkg.sv =====
// Shared types, constants and AES/CRC helper functions for the field cipher.
// No dependencies; used by all acfc modules.
`default_nettype none
package acfc_pkg;

   localparam logic [11:0] MAX_FIELD_BYTES = 12'd2048;
   localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

   // register indexes on the csr port
   localparam logic [2:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD1 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD2 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD3 = 3'd3;
   localparam logic [2:0] CSR_KEY_SIZE  = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       crc_step;
      logic [2:0] crc_idx;
      logic       add_first;
      logic       round;
      logic       last_round;
      logic       finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;
   } status_type;

   localparam logic [0:255][7:0] SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [0:255][7:0] INV_SBOX = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   localparam logic [0:10][7:0] RCON = {
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // inverse mix coefficients: 0 -> 0e, 1 -> 0b, 2 -> 0d, 3 -> 09
   function automatic logic [7:0] gm_inv(input logic [7:0] a, input logic [1:0] sel);
      logic [7:0] x2, x4, x8, r;
      x2 = xt(a);
      x4 = xt(x2);
      x8 = xt(x4);
      unique case (sel)
         2'd0:    r = x8 ^ x4 ^ x2;
         2'd1:    r = x8 ^ x2 ^ a;
         2'd2:    r = x8 ^ x4 ^ a;
         default: r = x8 ^ a;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
      return r;
   endfunction

   function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) r[127-8*i -: 8] = INV_SBOX[s[127-8*i -: 8]];
      return r;
   endfunction

   // byte r+4c of the state sits at bits 127-8*(r+4c)
   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      for (int ro = 0; ro < 4; ro++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) r[127-8*(ro+4*c) -: 8] = s[127-8*(ro+4*((c+4-ro)&3)) -: 8];
            else     r[127-8*(ro+4*c) -: 8] = s[127-8*(ro+4*((c+ro)&3)) -: 8];
         end
      end
      return r;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] r;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         r[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         r[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         r[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         r[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      return r;
   endfunction

   function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
      logic [127:0] r;
      logic [7:0]   acc;
      for (int c = 0; c < 4; c++) begin
         for (int ro = 0; ro < 4; ro++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++)
               acc = acc ^ gm_inv(s[127-8*(4*c+j) -: 8], 2'((j + 4 - ro) & 3));
            r[127-8*(4*c+ro) -: 8] = acc;
         end
      end
      return r;
   endfunction

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
      return x;
   endfunction

endpackage
`default_nettype wire

// ===== sv/acfc_keyexp.sv =====
// Key registers, key expansion sequencer and round key memory.
// Depends on acfc_pkg. One expanded word per cycle, one 128-bit row per round.
`default_nettype none
module acfc_keyexp (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_wdata,
   input  wire logic [3:0]   rk_addr,
   output logic      [127:0] rk_data,
   output logic      [3:0]   nr,
   output logic              busy
);
   import acfc_pkg::*;

   logic [63:0]  key_ff [4];
   logic [63:0]  key_in [4];
   logic [1:0]   ks_ff, ks_in;
   logic         busy_ff, busy_in;
   logic [5:0]   i_ff, i_in;
   logic [2:0]   j_ff, j_in;
   logic [3:0]   rc_ff, rc_in;
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [95:0]  stage_ff, stage_in;
   logic [127:0] rk_ff;
   logic [127:0] rk_mem [15];

   logic [1:0]   ks_eff;
   logic [3:0]   nk;
   logic [5:0]   last_i;
   logic [255:0] key256;
   logic [31:0]  t, new_word;
   logic         csr_hit;

   assign ks_eff = (ks_ff == 2'd3) ? 2'd2 : ks_ff;
   assign nk     = 4'd4 + {1'b0, ks_eff, 1'b0};
   assign nr     = 4'd10 + {1'b0, ks_eff, 1'b0};
   assign last_i = {nr, 2'b11};
   assign key256 = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
   assign busy   = busy_ff;
   assign csr_hit = csr_we && (csr_index <= CSR_KEY_SIZE);

   // next expanded word
   always_comb begin
      t = win_ff[0];
      if (j_ff == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {RCON[rc_ff], 24'd0};
      else if (nk == 4'd8 && j_ff == 3'd4) t = sub_word(t);
      if (i_ff < {2'b00, nk}) new_word = key256[255-32*i_ff[2:0] -: 32];
      else                    new_word = win_ff[3'(nk - 4'd1)] ^ t;
   end

   // sequencer and register writes
   always_comb begin
      key_in   = key_ff;
      ks_in    = ks_ff;
      busy_in  = busy_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      rc_in    = rc_ff;
      win_in   = win_ff;
      stage_in = stage_ff;
      if (busy_ff) begin
         win_in[0] = new_word;
         for (int k = 1; k < 8; k++) win_in[k] = win_ff[k-1];
         stage_in = {stage_ff[63:0], new_word};
         i_in     = i_ff + 6'd1;
         if ({1'b0, j_ff} == nk - 4'd1) begin
            j_in  = 3'd0;
            rc_in = rc_ff + 4'd1;
         end else begin
            j_in = j_ff + 3'd1;
         end
         if (i_ff == last_i) busy_in = 1'b0;
      end
      if (csr_hit) begin
         if (csr_index == CSR_KEY_SIZE) ks_in = csr_wdata[1:0];
         else key_in[csr_index[1:0]] = csr_wdata;
         busy_in = 1'b1;
         i_in    = 6'd0;
         j_in    = 3'd0;
         rc_in   = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) key_ff[k] <= 64'd0;
         ks_ff   <= 2'd0;
         busy_ff <= 1'b1;
         i_ff    <= 6'd0;
         j_ff    <= 3'd0;
         rc_ff   <= 4'd0;
      end else begin
         key_ff  <= key_in;
         ks_ff   <= ks_in;
         busy_ff <= busy_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         rc_ff   <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      stage_ff <= stage_in;
   end

   // round key memory: row written when its fourth word is produced
   always_ff @(posedge clock) begin
      if (busy_ff && !csr_hit && i_ff[1:0] == 2'b11)
         rk_mem[i_ff[5:2]] <= {stage_ff, new_word};
      rk_ff <= rk_mem[rk_addr];
   end

   assign rk_data = rk_ff;

endmodule
`default_nettype wire

// ===== sv/acfc_datapath.sv =====
// Block datapath: AES round unit, CBC chain, CRC-32 engine and result register.
// Depends on acfc_pkg; steered by acfc_ctrl through cmd_type.
`default_nettype none
module acfc_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire acfc_pkg::cmd_type    cmd,
   output acfc_pkg::status_type      status,
   input  wire logic                 in_mode,
   input  wire logic                 in_first,
   input  wire logic                 in_last,
   input  wire logic                 in_check,
   input  wire logic [11:0]          in_crc_len,
   input  wire logic [127:0]         in_block,
   input  wire logic [127:0]         rk_data,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic      [127:0]         out_block,
   output logic                      out_end,
   output logic                      out_bad
);
   import acfc_pkg::*;

   logic [127:0] blk_ff, blk_in, ct_ff, ct_in, chain_ff, chain_in;
   logic [31:0]  crc_ff, crc_in, stored_ff, stored_in;
   logic [11:0]  pos_ff, pos_in, len_ff, len_in;
   logic         dec_ff, dec_in, last_ff, last_in, check_ff, check_in;
   logic         rv_ff, rv_in;
   logic [127:0] rd_ff, rd_in;
   logic         re_ff, re_in, rb_ff, rb_in;

   logic [127:0] rnd_x;
   logic [11:0]  p, d;
   logic [3:0]   bi;
   logic [7:0]   bv;

   always_comb begin
      blk_in    = blk_ff;
      ct_in     = ct_ff;
      chain_in  = chain_ff;
      crc_in    = crc_ff;
      stored_in = stored_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      dec_in    = dec_ff;
      last_in   = last_ff;
      check_in  = check_ff;
      rd_in     = rd_ff;
      re_in     = re_ff;
      rb_in     = rb_ff;
      rv_in     = rsp_tready ? 1'b0 : rv_ff;
      rnd_x     = blk_ff;
      p         = 12'd0;
      d         = 12'd0;
      bi        = 4'd0;
      bv        = 8'd0;

      // take a new transaction
      if (cmd.load) begin
         blk_in   = in_block;
         ct_in    = in_block;
         dec_in   = in_mode;
         last_in  = in_last;
         check_in = in_check;
         len_in   = (in_crc_len > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : in_crc_len;
         if (in_first) begin
            chain_in  = 128'd0;
            crc_in    = 32'hFFFF_FFFF;
            stored_in = 32'd0;
            pos_in    = 12'd0;
         end
      end

      // two plaintext bytes through the CRC window
      if (cmd.crc_step) begin
         for (int b = 0; b < 2; b++) begin
            bi = {cmd.crc_idx, 1'(b)};
            p  = pos_ff + {8'd0, bi};
            d  = p - len_ff;
            bv = blk_in[127-8*bi -: 8];
            if (p < len_ff) begin
               crc_in = crc_byte(crc_in, bv);
            end else if (d < 12'd4 && (dec_ff || check_ff)) begin
               if (!dec_ff) begin
                  bv = crc_in[8*d[1:0] +: 8];
                  blk_in[127-8*bi -: 8] = bv;
               end
               stored_in[8*d[1:0] +: 8] = bv;
            end
         end
      end

      // initial key add
      if (cmd.add_first)
         blk_in = dec_ff ? (blk_ff ^ rk_data) : (blk_ff ^ chain_ff ^ rk_data);

      // one cipher round
      if (cmd.round) begin
         if (dec_ff) begin
            rnd_x = inv_sub_bytes(shift_rows(blk_ff, 1'b1)) ^ rk_data;
            blk_in = cmd.last_round ? (rnd_x ^ chain_ff) : inv_mix_cols(rnd_x);
         end else begin
            rnd_x = shift_rows(sub_bytes(blk_ff), 1'b0);
            blk_in = (cmd.last_round ? rnd_x : mix_cols(rnd_x)) ^ rk_data;
         end
      end

      // hand the block to the result register
      if (cmd.finish) begin
         rv_in    = 1'b1;
         rd_in    = blk_ff;
         re_in    = last_ff;
         rb_in    = dec_ff && last_ff && check_ff && (crc_ff != stored_ff);
         chain_in = dec_ff ? ct_ff : blk_ff;
         pos_in   = pos_ff + 12'd16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff  <= 128'd0;
         crc_ff    <= 32'hFFFF_FFFF;
         stored_ff <= 32'd0;
         pos_ff    <= 12'd0;
         rv_ff     <= 1'b0;
      end else begin
         chain_ff  <= chain_in;
         crc_ff    <= crc_in;
         stored_ff <= stored_in;
         pos_ff    <= pos_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff   <= blk_in;
      ct_ff    <= ct_in;
      len_ff   <= len_in;
      dec_ff   <= dec_in;
      last_ff  <= last_in;
      check_ff <= check_in;
      rd_ff    <= rd_in;
      re_ff    <= re_in;
      rb_ff    <= rb_in;
   end

   assign status.out_busy = rv_ff && !rsp_tready;
   assign rsp_tvalid      = rv_ff;
   assign out_block       = rd_ff;
   assign out_end         = re_ff;
   assign out_bad         = rb_ff;

endmodule
`default_nettype wire

// ===== sv/acfc_ctrl.sv =====
// Controller state machine: sequences CRC passes, key add and cipher rounds.
// Depends on acfc_pkg; drives acfc_datapath and the round key read address.
`default_nettype none
module acfc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic                 in_mode,
   input  wire logic                 kx_busy,
   input  wire logic [3:0]           nr,
   input  wire acfc_pkg::status_type status,
   output acfc_pkg::cmd_type         cmd,
   output logic      [3:0]           rk_addr
);
   import acfc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CRC   = 6'b000010,
      S_KEY0  = 6'b000100,
      S_ADDK  = 6'b001000,
      S_ROUND = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [3:0] rnd_ff, rnd_in;
   logic       dec_ff, dec_in;
   logic       fin;

   assign req_tready = (state_ff == S_IDLE) && !kx_busy;
   assign fin        = dec_ff ? (rnd_ff == 4'd0) : (rnd_ff == nr);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      dec_in   = dec_ff;
      cmd      = '0;
      rk_addr  = 4'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               dec_in   = in_mode;
               cnt_in   = 3'd0;
               state_in = in_mode ? S_KEY0 : S_CRC;
            end
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            cmd.crc_idx  = cnt_ff;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) state_in = dec_ff ? S_DONE : S_KEY0;
         end
         S_KEY0: begin
            rk_addr  = dec_ff ? nr : 4'd0;
            state_in = S_ADDK;
         end
         S_ADDK: begin
            cmd.add_first = 1'b1;
            rk_addr       = dec_ff ? (nr - 4'd1) : 4'd1;
            rnd_in        = rk_addr;
            state_in      = S_ROUND;
         end
         S_ROUND: begin
            cmd.round      = 1'b1;
            cmd.last_round = fin;
            rk_addr        = dec_ff ? (rnd_ff - 4'd1) : (rnd_ff + 4'd1);
            rnd_in         = rk_addr;
            if (fin) begin
               cnt_in   = 3'd0;
               state_in = dec_ff ? S_CRC : S_DONE;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd0;
         rnd_ff   <= 4'd0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         dec_ff   <= dec_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/aes_cbc_field_cipher_top.sv =====
// AES-128/192/256 CBC field cipher with CRC-32 insert/check, one block per transaction.
// Steps per block: the accept, CRC passes at two bytes each, a key-memory read, a key add, the
// cipher rounds and a handoff; decryption runs its CRC passes after the rounds instead.
// A waiting result holds the next block in its handoff state until the older one is taken.
// Reset clears the key registers and runs key expansion, tready low meanwhile;
// every key register write reruns expansion.
`default_nettype none
module aes_cbc_field_cipher_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // crc_len[11:0], data_hi[75:12], data_lo[139:76], zero pad[143:140]
   input  wire logic [143:0] req_tdata,
   // mode[0], first_block[1], check_crc[2]
   input  wire logic [2:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_hi[63:0], out_lo[127:64]
   output logic      [127:0] rsp_tdata,
   // crc_bad[0]
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   import acfc_pkg::*;

   cmd_type      cmd;
   status_type   status;
   logic [3:0]   rk_addr, nr;
   logic [127:0] rk_data, out_block;
   logic         kx_busy;

   acfc_keyexp u_keyexp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rk_addr   (rk_addr),
      .rk_data   (rk_data),
      .nr        (nr),
      .busy      (kx_busy)
   );

   acfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_mode    (req_tuser[0]),
      .kx_busy    (kx_busy),
      .nr         (nr),
      .status     (status),
      .cmd        (cmd),
      .rk_addr    (rk_addr)
   );

   acfc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_mode    (req_tuser[0]),
      .in_first   (req_tuser[1]),
      .in_last    (req_tlast),
      .in_check   (req_tuser[2]),
      .in_crc_len (req_tdata[11:0]),
      .in_block   ({req_tdata[75:12], req_tdata[139:76]}),
      .rk_data    (rk_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_block  (out_block),
      .out_end    (rsp_tlast),
      .out_bad    (rsp_tuser)
   );

   assign rsp_tdata = {out_block[63:0], out_block[127:64]};

`include "aes_cbc_field_cipher_top_macros.svh"

   // one block in flight: no accept right after an accept
   `ACFC_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // a CRC mismatch is only flagged on the field's last block
   `ACFC_ASSERT_IMP(a_bad_on_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   // a key register write restarts expansion and blocks input
   `ACFC_ASSERT_NXT(a_csr_expands, clock, reset, csr_we && csr_index <= CSR_KEY_SIZE, !req_tready)

endmodule
`default_nettype wire

// ===== dv/acfc_field_checker.sv =====
// Checker for the AES-CBC field cipher: watches the request, response and CSR channels,
// predicts each response block and compares it field by field. Depends on acfc_pkg.
`default_nettype none
module acfc_field_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [143:0] req_tdata,
   input  wire logic [2:0]   req_tuser,
   input  wire logic         req_tlast,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic         rsp_tuser,
   input  wire logic         rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_wdata,
   output int                fail_count,
   output int                outstanding,
   output int                crc_bad_seen
);
   import acfc_pkg::*;

   typedef logic [0:15][7:0] block_type;

   typedef struct {
      logic [63:0] out_hi;
      logic [63:0] out_lo;
      logic        field_end;
      logic        crc_bad;
   } cipher_result_type;

   localparam logic [0:255][7:0] FWD_SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};
   localparam logic [0:10][7:0] ROUND_CONST = {
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
   localparam logic [0:3][7:0] FWD_MIX = {8'h02, 8'h03, 8'h01, 8'h01};
   localparam logic [0:3][7:0] INV_MIX = {8'h0e, 8'h0b, 8'h0d, 8'h09};
   localparam logic [31:0]     CRC_REFLECTED = 32'hEDB88320;

   logic [7:0]        inv_box [256];
   logic [63:0]       key_reg [4];
   logic [1:0]        key_size_reg;
   logic [31:0]       sched [60];
   block_type         chain_ct;
   logic [31:0]       field_crc;
   logic [31:0]       captured_crc;
   logic [11:0]       field_pos;
   cipher_result_type expected_q [$];
   int                mismatches;

   initial begin
      for (int i = 0; i < 256; i++) inv_box[FWD_SBOX[i]] = i[7:0];
   end

   function automatic int round_count();
      return (key_size_reg == 2'd0) ? 10 : (key_size_reg == 2'd1) ? 12 : 14;
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
   endfunction

   // key expansion from the current key registers
   function automatic void load_schedule();
      int          nk;
      int          total;
      logic [31:0] t;
      nk = round_count() - 6;
      total = 4 * (round_count() + 1);
      for (int i = 0; i < 60; i++) sched[i] = '0;
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = sched[i-1];
         if (i % nk == 0)
            t = sbox_word({t[23:0], t[31:24]}) ^ {ROUND_CONST[i / nk], 24'h0};
         else if (nk == 8 && i % nk == 4)
            t = sbox_word(t);
         sched[i] = sched[i-nk] ^ t;
      end
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic       hi;
      p = '0;
      for (int k = 0; k < 8; k++) begin
         hi = a[7];
         if (b[0]) p = p ^ a;
         a = {a[6:0], 1'b0};
         if (hi) a = a ^ 8'h1b;
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic block_type key_add(input block_type s, input int r);
      logic [31:0] w;
      for (int c = 0; c < 4; c++) begin
         w = sched[4*r + c];
         for (int k = 0; k < 4; k++) s[4*c + k] = s[4*c + k] ^ w[31-8*k -: 8];
      end
      return s;
   endfunction

   function automatic block_type row_shift(input block_type s, input logic inv);
      block_type t;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[r + 4*c] = inv ? s[r + 4*((c + 4 - r) & 3)] : s[r + 4*((c + r) & 3)];
      return t;
   endfunction

   function automatic block_type col_mix(input block_type s, input logic [0:3][7:0] m);
      block_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[4*c + r] = gf_mul(s[4*c], m[(4 - r) & 3]) ^ gf_mul(s[4*c+1], m[(5 - r) & 3])
                       ^ gf_mul(s[4*c+2], m[(6 - r) & 3]) ^ gf_mul(s[4*c+3], m[(7 - r) & 3]);
      return t;
   endfunction

   function automatic block_type encipher(input block_type s);
      int nr;
      nr = round_count();
      s = key_add(s, 0);
      for (int r = 1; r <= nr; r++) begin
         for (int i = 0; i < 16; i++) s[i] = FWD_SBOX[s[i]];
         s = row_shift(s, 1'b0);
         if (r != nr) s = col_mix(s, FWD_MIX);
         s = key_add(s, r);
      end
      return s;
   endfunction

   function automatic block_type decipher(input block_type s);
      int nr;
      nr = round_count();
      s = key_add(s, nr);
      for (int r = nr - 1; r >= 0; r--) begin
         s = row_shift(s, 1'b1);
         for (int i = 0; i < 16; i++) s[i] = inv_box[s[i]];
         s = key_add(s, r);
         if (r != 0) s = col_mix(s, INV_MIX);
      end
      return s;
   endfunction

   function automatic void crc_step(input logic [7:0] b);
      field_crc = field_crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++)
         field_crc = (field_crc >> 1) ^ (field_crc[0] ? CRC_REFLECTED : 32'h0);
   endfunction

   function automatic void start_field();
      chain_ct = '0;
      field_crc = '1;
      captured_crc = '0;
      field_pos = '0;
   endfunction

   // one request transaction -> one expected response
   function automatic cipher_result_type cipher_block(input logic [143:0] d,
                                                      input logic [2:0] u,
                                                      input logic last);
      cipher_result_type res;
      logic              dec;
      logic              check;
      logic [11:0]       crc_len;
      logic [11:0]       p;
      logic [11:0]       off;
      block_type         blk;
      block_type         ct;
      dec = u[0];
      check = u[2];
      crc_len = (d[11:0] > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : d[11:0];
      if (u[1]) start_field();
      blk = {d[75:12], d[139:76]};
      ct = blk;
      if (dec) blk = decipher(blk) ^ chain_ct;
      for (int i = 0; i < 16; i++) begin
         p = field_pos + 12'(i);
         off = p - crc_len;
         if (p < crc_len) crc_step(blk[i]);
         else if (off < 12'd4 && (dec || check)) begin
            if (!dec) blk[i] = field_crc[8*off +: 8];
            captured_crc[8*off +: 8] = blk[i];
         end
      end
      if (!dec) begin
         blk = encipher(blk ^ chain_ct);
         ct = blk;
      end
      chain_ct = ct;
      field_pos = field_pos + 12'd16;
      res.out_hi = blk[0:7];
      res.out_lo = blk[8:15];
      res.field_end = last;
      res.crc_bad = dec && last && check && (field_crc != captured_crc);
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_result_type exp_r;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         key_size_reg = '0;
         start_field();
         load_schedule();
         expected_q.delete();
         fail_count <= 0;
         crc_bad_seen <= 0;
         mismatches = 0;
      end else begin
         // key register writes
         if (csr_we && csr_index <= CSR_KEY_SIZE) begin
            if (csr_index == CSR_KEY_SIZE) key_size_reg = csr_wdata[1:0];
            else key_reg[csr_index[1:0]] = csr_wdata;
            load_schedule();
         end
         // response transaction against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser) crc_bad_seen <= crc_bad_seen + 1;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected response %h last=%b crc_bad=%b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_tdata[63:0] !== exp_r.out_hi || rsp_tdata[127:64] !== exp_r.out_lo ||
                   rsp_tlast !== exp_r.field_end || rsp_tuser !== exp_r.crc_bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: exp hi=%h lo=%h end=%b bad=%b, got hi=%h lo=%h end=%b bad=%b",
                              exp_r.out_hi, exp_r.out_lo, exp_r.field_end, exp_r.crc_bad,
                              rsp_tdata[63:0], rsp_tdata[127:64], rsp_tlast, rsp_tuser);
               end
            end
         end
         // request transaction
         if (req_tvalid && req_tready)
            expected_q.push_back(cipher_block(req_tdata, req_tuser, req_tlast));
         fail_count <= mismatches;
      end
      outstanding <= expected_q.size();
   end

endmodule
`default_nettype wire

// ===== dv/aes_cbc_field_cipher_top_tb.sv =====
// Testbench top for the AES-CBC field cipher: drives key writes and field blocks,
// sets handshake pressure and reports the verdict. Depends on acfc_pkg and acfc_field_checker.
`default_nettype none
module aes_cbc_field_cipher_top_tb;
   import acfc_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;
   int           fail_count;
   int           outstanding;
   int           crc_bad_seen;

   int           send_idle_pct;
   int           rsp_stall_pct;
   int           blocks_sent;
   int           fields_sent;
   int           quiet_cycles;
   logic [63:0]  ct_hi_q [$];
   logic [63:0]  ct_lo_q [$];

   aes_cbc_field_cipher_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   acfc_field_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding), .crc_bad_seen(crc_bad_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ciphertext capture for decrypt replay
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ct_hi_q.push_back(rsp_tdata[63:0]);
         ct_lo_q.push_back(rsp_tdata[127:64]);
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("aes_cbc_field_cipher_top_tb: FAIL");
         $finish;
      end
   end

   task automatic send_block(input logic mode, input logic first, input logic last,
                             input logic check, input logic [11:0] crc_len,
                             input logic [63:0] hi, input logic [63:0] lo);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'h0, lo, hi, crc_len};
      req_tuser <= {check, first, mode};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
      if (last) fields_sent++;
   endtask

   // pause until every response is back, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] w0, input logic [63:0] w1, input logic [63:0] w2,
                           input logic [63:0] w3, input logic [1:0] ks);
      logic [63:0] vals [5];
      vals = '{w0, w1, w2, w3, {62'h0, ks}};
      drain();
      for (int i = 0; i <= CSR_KEY_SIZE; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_field(input logic mode, input int nblk, input logic check,
                             input logic [11:0] crc_len);
      for (int b = 0; b < nblk; b++)
         send_block(mode, b == 0, b == nblk - 1, check, crc_len, rand64(), rand64());
   endtask

   // encrypt a field, then decrypt its ciphertext, optionally with one bit flipped
   task automatic round_trip(input int nblk, input logic check, input logic [11:0] crc_len,
                             input logic corrupt);
      int          hit;
      logic [63:0] hi;
      drain();
      ct_hi_q.delete();
      ct_lo_q.delete();
      send_field(1'b0, nblk, check, crc_len);
      drain();
      hit = $urandom_range(nblk - 1);
      for (int b = 0; b < nblk; b++) begin
         hi = ct_hi_q[b];
         if (corrupt && b == hit) hi[$urandom_range(63)] ^= 1'b1;
         send_block(1'b1, b == 0, b == nblk - 1, check, crc_len, hi, ct_lo_q[b]);
      end
   endtask

   task automatic random_phase(input int target);
      int          start;
      int          nblk;
      int          pick;
      start = blocks_sent;
      while (blocks_sent - start < target) begin
         pick = $urandom_range(99);
         nblk = $urandom_range(1, 6);
         if (pick < 45)
            round_trip(nblk, $urandom_range(9) != 0, 12'($urandom_range(16*nblk - 4)),
                       $urandom_range(3) == 0);
         else if (pick < 70)
            send_field(1'b0, nblk, $urandom_range(1), 12'($urandom_range(16*nblk + 8)));
         else if (pick < 85)
            send_field(1'b1, nblk, 1'b1, 12'($urandom_range(16*nblk + 8)));
         else
            send_block($urandom_range(1), $urandom_range(1), $urandom_range(1),
                       $urandom_range(1), 12'($urandom_range(4095)), rand64(), rand64());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      blocks_sent = 0;
      fields_sent = 0;
      quiet_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed blocks under the all-zero reset key
      send_block(1'b0, 1'b1, 1'b1, 1'b1, 12'd0, '0, '0);
      send_block(1'b0, 1'b1, 1'b1, 1'b1, 12'hFFF, '1, '1);        // crc_len saturates
      send_block(1'b1, 1'b1, 1'b1, 1'b1, 12'd12, '1, '1);
      send_block(1'b0, 1'b1, 1'b1, 1'b0, 12'd4, rand64(), rand64()); // no CRC word
      send_block(1'b1, 1'b1, 1'b1, 1'b1, 12'd14, rand64(), rand64()); // word past field end
      send_block(1'b1, 1'b1, 1'b1, 1'b0, 12'd8, rand64(), rand64());
      // continued field without first_block, modes mixed
      send_block(1'b0, 1'b1, 1'b0, 1'b1, 12'd20, rand64(), rand64());
      send_block(1'b0, 1'b0, 1'b0, 1'b1, 12'd20, rand64(), rand64());
      send_block(1'b1, 1'b0, 1'b1, 1'b1, 12'd20, rand64(), rand64());
      send_block(1'b1, 1'b0, 1'b1, 1'b1, 12'd2048, rand64(), rand64());
      round_trip(2, 1'b1, 12'd24, 1'b0);
      round_trip(2, 1'b1, 12'd24, 1'b1);

      // phase 0: AES-128, no idling, plus one field long enough to wrap the byte offset
      load_key(rand64(), rand64(), rand64(), rand64(), 2'd0);
      round_trip(1, 1'b1, 12'd12, 1'b0);
      send_field(1'b0, 260, 1'b1, 12'd2048);
      random_phase(300);

      // phase 1: AES-192 with an all-ones key, sender mostly idle
      load_key('1, '1, '1, '1, 2'd1);
      send_idle_pct = 81;
      random_phase(300);

      // phase 2: AES-256, receiver mostly stalled
      load_key(rand64(), rand64(), rand64(), rand64(), 2'd2);
      send_idle_pct = 0;
      rsp_stall_pct = 81;
      random_phase(300);

      // phase 3: key size three aliases AES-256, light idling on both sides
      load_key(rand64(), rand64(), rand64(), rand64(), 2'd3);
      send_idle_pct = 12;
      rsp_stall_pct = 12;
      random_phase(300);

      drain();
      $display("Sent %0d blocks in %0d fields over four key settings and idle mixes;",
               blocks_sent, fields_sent);
      $display("round trips, corrupted fields and noise gave %0d CRC mismatch flags.",
               crc_bad_seen);
      if (fail_count == 0)
         $display("aes_cbc_field_cipher_top_tb: PASS");
      else
         $display("aes_cbc_field_cipher_top_tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ===== aes_cbc_field_cipher_top.f =====
+incdir+sv
sv/acfc_pkg.sv
sv/acfc_keyexp.sv
sv/acfc_datapath.sv
sv/acfc_ctrl.sv
sv/aes_cbc_field_cipher_top.sv
dv/acfc_field_checker.sv
dv/aes_cbc_field_cipher_top_tb.sv
